FILE: hw/rtl/battery_charge_monitor_controller_assert.svh
// Assertion macros used by the checker file.
`ifndef BATTERY_CHARGE_MONITOR_CONTROLLER_ASSERT_SVH
`define BATTERY_CHARGE_MONITOR_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BCM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bcm assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bcm assertion failed");

`endif

FILE: hw/rtl/bcm_pkg.sv
// ----------------------------------------------------------------------------
// bcm_pkg
// Types, constants and arithmetic helpers of the battery charge monitor.
// ----------------------------------------------------------------------------
package bcm_pkg;

  localparam int CELL_COUNT    = 12;
  localparam int CELL_IDX_W    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int TIMEOUT_LIMIT = 10;
  localparam int TIMEOUT_W     = $clog2(TIMEOUT_LIMIT + 1);

  typedef enum logic [2:0] {
    ACT_FRAME = 3'd0,
    ACT_CTRL  = 3'd1,
    ACT_POLL  = 3'd2,
    ACT_READ  = 3'd3,
    ACT_CLEAR = 3'd4
  } action_e;

  localparam logic [10:0] ID_FIRST    = 11'h200;
  localparam logic [10:0] ID_LAST     = 11'h210;
  localparam logic [10:0] ID_CAPACITY = 11'h200;
  localparam logic [10:0] ID_CURRENT  = 11'h201;
  localparam logic [10:0] ID_CELL     = 11'h202;
  localparam logic [10:0] ID_TEMP     = 11'h209;
  localparam logic [10:0] ID_PACK_ID  = 11'h210;

  localparam logic [4:0] REG_ID0        = 5'd0;
  localparam logic [4:0] REG_ID1        = 5'd1;
  localparam logic [4:0] REG_CURRENT    = 5'd2;
  localparam logic [4:0] REG_SUM        = 5'd3;
  localparam logic [4:0] REG_CAPACITY   = 5'd4;
  localparam logic [4:0] REG_PERCENT    = 5'd5;
  localparam logic [4:0] REG_STATUS     = 5'd6;
  localparam logic [4:0] REG_TEMP       = 5'd7;
  localparam logic [4:0] REG_CELL_FIRST = 5'd8;
  localparam logic [4:0] REG_CELL_LAST  = 5'd19;
  localparam logic [4:0] REG_DOOR       = 5'd20;
  localparam logic [4:0] REG_ZERO       = 5'd21;
  localparam logic [4:0] REG_SETPOINT   = 5'd22;

  localparam logic [19:0] SUM_EMPTY = 20'd35600;
  localparam logic [19:0] SUM_FULL  = 20'd49600;
  localparam logic [6:0]  PCT_FULL  = 7'd100;
  localparam logic [6:0]  PCT_NEAR  = 7'd98;

  localparam logic [8:0]  SETPOINT_MAX   = 9'd330;
  localparam logic [8:0]  SETPOINT_RESET = 9'd80;
  localparam logic [11:0] DAC_MAX        = 12'd4095;

  // ceil(101 * 2^28 / 14001) and ceil(2048 * 2^17 / 165); exact floors over
  // the 14-bit sum offset and the 9-bit step
  localparam logic [20:0] PCT_RECIP = 21'd1936432;
  localparam logic [20:0] DAC_RECIP = 21'd1626882;

  typedef struct packed {
    logic [2:0]  action;
    logic [10:0] can_id;
    logic [47:0] can_payload;
    logic        door_closed;
    logic        ramp_due;
    logic [4:0]  reg_index;
  } item_t;

  typedef struct packed {
    logic        charge_enable;
    logic        led_charging;
    logic        led_full;
    logic [11:0] dac_code;
    logic        send_wake;
    logic [15:0] read_data;
    logic        read_error;
    logic [6:0]  charge_percent;
  } result_t;

  // (sum - 35600) * 101 / 14001, clamped to 0 and 100
  function automatic logic [6:0] pct_of_sum(logic [19:0] sum);
    logic [13:0] diff;
    logic [34:0] prod;
    logic [6:0]  q;
    diff = 14'(sum - SUM_EMPTY);
    prod = 35'(diff) * 35'(PCT_RECIP);
    q    = prod[34:28];
    if (sum < SUM_EMPTY) begin
      q = '0;
    end else if (sum > SUM_FULL) begin
      q = PCT_FULL;
    end
    return q;
  endfunction

  // floor(step * 4096 / 330), saturated
  function automatic logic [11:0] dac_of_step(logic [8:0] step);
    logic [29:0] prod;
    logic [12:0] q;
    logic [11:0] code;
    prod = 30'(step) * 30'(DAC_RECIP);
    q    = prod[29:17];
    code = (q > 13'(DAC_MAX)) ? DAC_MAX : q[11:0];
    return code;
  endfunction

endpackage

FILE: hw/rtl/bcm_in_stage.sv
// ----------------------------------------------------------------------------
// bcm_in_stage
// Input register; takes a new item when empty or whenever the held one moves on.
// ----------------------------------------------------------------------------
module bcm_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  bcm_pkg::item_t item_i,
  input  logic           advance_i,
  output logic           valid_o,
  output bcm_pkg::item_t item_o
);

  logic           valid_q, valid_d;
  bcm_pkg::item_t item_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: hw/rtl/bcm_core.sv
// ----------------------------------------------------------------------------
// bcm_core
// Pack data, charge state and pin levels; one item updates them per cycle when fired.
// ----------------------------------------------------------------------------
module bcm_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [8:0]       cfg_wdata_i,
  input  logic             fire_i,
  input  bcm_pkg::item_t   item_i,
  output bcm_pkg::result_t result_o
);

  logic [15:0] cells_q [bcm_pkg::CELL_COUNT];
  logic [15:0] cells_d [bcm_pkg::CELL_COUNT];
  logic [19:0] total_q, total_d;
  logic [19:0] sum_q, sum_d;
  logic [6:0]  pct_q, pct_d;
  logic [15:0] cap_q, cap_d;
  logic [15:0] cur_q, cur_d;
  logic [15:0] temp_q, temp_d;
  logic [15:0] id0_q, id0_d;
  logic [15:0] id1_q, id1_d;
  logic [7:0]  status_q, status_d;
  logic [bcm_pkg::TIMEOUT_W-1:0] tmo_q, tmo_d;
  logic        active_q, active_d;
  logic [8:0]  step_q, step_d;
  logic        en_q, en_d;
  logic        ledc_q, ledc_d;
  logic        ledf_q, ledf_d;
  logic [11:0] dac_q, dac_d;
  logic [8:0]  sp_q, sp_d;

  logic [7:0]  byte0;
  logic [7:0]  byte5;
  logic [15:0] word0;
  logic [15:0] word1;
  logic [15:0] word2;
  logic [4:0]  rd_off;
  logic [7:0]  cell_addr;
  logic        cell_hit;
  logic [15:0] cell_old;
  logic        live;
  logic        clr;
  logic [19:0] total_new;
  logic [8:0]  step_nx;
  logic [bcm_pkg::TIMEOUT_W:0] tmo_inc;
  logic        wake;
  logic        rd_err;
  logic [15:0] rd_data;

  assign byte0  = item_i.can_payload[47:40];
  assign byte5  = item_i.can_payload[7:0];
  assign word0  = item_i.can_payload[47:32];
  assign word1  = item_i.can_payload[39:24];
  assign word2  = item_i.can_payload[31:16];
  assign rd_off = item_i.reg_index - bcm_pkg::REG_CELL_FIRST;

  assign cell_addr = (item_i.action == bcm_pkg::ACT_FRAME) ? byte0 : {3'b0, rd_off};
  assign cell_hit  = cell_addr < 8'(bcm_pkg::CELL_COUNT);
  assign cell_old  = cell_hit ? cells_q[cell_addr[bcm_pkg::CELL_IDX_W-1:0]] : '0;
  assign live      = tmo_q < bcm_pkg::TIMEOUT_W'(bcm_pkg::TIMEOUT_LIMIT);
  assign tmo_inc   = {1'b0, tmo_q} + 1'b1;

  assign sp_d = (cfg_wdata_i > bcm_pkg::SETPOINT_MAX) ? bcm_pkg::SETPOINT_MAX : cfg_wdata_i;

  always_comb begin
    cells_d   = cells_q;
    total_d   = total_q;
    sum_d     = sum_q;
    pct_d     = pct_q;
    cap_d     = cap_q;
    cur_d     = cur_q;
    temp_d    = temp_q;
    id0_d     = id0_q;
    id1_d     = id1_q;
    status_d  = status_q;
    tmo_d     = tmo_q;
    active_d  = active_q;
    step_d    = step_q;
    en_d      = en_q;
    ledc_d    = ledc_q;
    ledf_d    = ledf_q;
    dac_d     = dac_q;
    clr       = 1'b0;
    wake      = 1'b0;
    rd_err    = 1'b0;
    rd_data   = '0;
    total_new = total_q;
    step_nx   = (step_q < sp_q) ? step_q + 9'd1 : sp_q;

    unique case (item_i.action)
      bcm_pkg::ACT_FRAME: begin
        if (item_i.can_id >= bcm_pkg::ID_FIRST && item_i.can_id <= bcm_pkg::ID_LAST) begin
          tmo_d = '0;
          unique case (item_i.can_id)
            bcm_pkg::ID_CAPACITY: cap_d = word0;
            bcm_pkg::ID_CURRENT:  cur_d = word0;
            bcm_pkg::ID_CELL: begin
              status_d = byte5;
              if (cell_hit) begin
                cells_d[cell_addr[bcm_pkg::CELL_IDX_W-1:0]] = word1;
                total_new = total_q - 20'(cell_old) + 20'(word1);
              end
            end
            bcm_pkg::ID_TEMP: temp_d = word1;
            bcm_pkg::ID_PACK_ID: begin
              id0_d = word0;
              id1_d = word2;
            end
            default: ;
          endcase
          total_d = total_new;
          sum_d   = total_new;
          pct_d   = bcm_pkg::pct_of_sum(total_new);
        end
      end
      bcm_pkg::ACT_CTRL: begin
        if (item_i.door_closed && pct_q < bcm_pkg::PCT_FULL) begin
          en_d = 1'b1;
          if (active_q && item_i.ramp_due) begin
            step_d = step_nx;
            dac_d  = bcm_pkg::dac_of_step(step_nx);
          end
        end else begin
          en_d = 1'b0;
          if (!active_q) begin
            dac_d  = '0;
            step_d = '0;
          end
        end
        if (live && pct_q >= bcm_pkg::PCT_FULL) begin
          active_d = 1'b0;
          ledc_d   = 1'b0;
          ledf_d   = 1'b1;
        end else if (live && pct_q > bcm_pkg::PCT_NEAR) begin
          ledc_d = 1'b0;
          ledf_d = 1'b1;
        end else if (live) begin
          active_d = 1'b1;
          ledc_d   = 1'b1;
          ledf_d   = 1'b0;
        end else begin
          step_d = '0;
          ledc_d = 1'b0;
          ledf_d = 1'b0;
        end
      end
      bcm_pkg::ACT_POLL: begin
        wake = 1'b1;
        if (tmo_inc >= (bcm_pkg::TIMEOUT_W + 1)'(bcm_pkg::TIMEOUT_LIMIT)) begin
          tmo_d   = bcm_pkg::TIMEOUT_W'(bcm_pkg::TIMEOUT_LIMIT);
          clr     = 1'b1;
          sum_d   = '0;
          pct_d   = '0;
        end else begin
          tmo_d = tmo_inc[bcm_pkg::TIMEOUT_W-1:0];
        end
      end
      bcm_pkg::ACT_READ: begin
        if (item_i.reg_index > bcm_pkg::REG_SETPOINT) begin
          rd_err = 1'b1;
        end else begin
          unique case (item_i.reg_index)
            bcm_pkg::REG_ID0:      rd_data = id0_q;
            bcm_pkg::REG_ID1:      rd_data = id1_q;
            bcm_pkg::REG_CURRENT:  rd_data = cur_q;
            bcm_pkg::REG_SUM:      rd_data = sum_q[15:0];
            bcm_pkg::REG_CAPACITY: rd_data = cap_q;
            bcm_pkg::REG_PERCENT:  rd_data = 16'(pct_q);
            bcm_pkg::REG_STATUS:   rd_data = 16'(status_q);
            bcm_pkg::REG_TEMP:     rd_data = temp_q;
            bcm_pkg::REG_DOOR:     rd_data = 16'(!item_i.door_closed);
            bcm_pkg::REG_ZERO:     rd_data = '0;
            bcm_pkg::REG_SETPOINT: rd_data = 16'(sp_q);
            default: begin
              if (item_i.reg_index >= bcm_pkg::REG_CELL_FIRST &&
                  item_i.reg_index <= bcm_pkg::REG_CELL_LAST && cell_hit) begin
                rd_data = cell_old;
              end
            end
          endcase
        end
      end
      bcm_pkg::ACT_CLEAR: begin
        wake = 1'b1;
        clr  = 1'b1;
      end
      default: ;
    endcase

    if (clr) begin
      for (int i = 0; i < bcm_pkg::CELL_COUNT; i++) begin
        cells_d[i] = '0;
      end
      total_d  = '0;
      cap_d    = '0;
      cur_d    = '0;
      temp_d   = '0;
      id0_d    = '0;
      id1_d    = '0;
      status_d = '0;
      active_d = 1'b0;
    end
  end

  always_comb begin
    result_o.charge_enable  = en_d;
    result_o.led_charging   = ledc_d;
    result_o.led_full       = ledf_d;
    result_o.dac_code       = dac_d;
    result_o.send_wake      = wake;
    result_o.read_data      = rd_data;
    result_o.read_error     = rd_err;
    result_o.charge_percent = pct_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= bcm_pkg::SETPOINT_RESET;
    end else if (cfg_we_i) begin
      sp_q <= sp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bcm_pkg::CELL_COUNT; i++) begin
        cells_q[i] <= '0;
      end
      total_q  <= '0;
      sum_q    <= '0;
      pct_q    <= '0;
      cap_q    <= '0;
      cur_q    <= '0;
      temp_q   <= '0;
      id0_q    <= '0;
      id1_q    <= '0;
      status_q <= '0;
      tmo_q    <= '0;
      active_q <= 1'b0;
      step_q   <= '0;
      en_q     <= 1'b0;
      ledc_q   <= 1'b0;
      ledf_q   <= 1'b0;
      dac_q    <= '0;
    end else if (fire_i) begin
      cells_q  <= cells_d;
      total_q  <= total_d;
      sum_q    <= sum_d;
      pct_q    <= pct_d;
      cap_q    <= cap_d;
      cur_q    <= cur_d;
      temp_q   <= temp_d;
      id0_q    <= id0_d;
      id1_q    <= id1_d;
      status_q <= status_d;
      tmo_q    <= tmo_d;
      active_q <= active_d;
      step_q   <= step_d;
      en_q     <= en_d;
      ledc_q   <= ledc_d;
      ledf_q   <= ledf_d;
      dac_q    <= dac_d;
    end
  end

endmodule

FILE: hw/rtl/bcm_out_stage.sv
// ----------------------------------------------------------------------------
// bcm_out_stage
// Result register; loads when empty or when its item is taken.
// ----------------------------------------------------------------------------
module bcm_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_valid_i,
  input  bcm_pkg::result_t result_i,
  output logic             load_ok_o,
  output logic             valid_o,
  input  logic             ready_i,
  output bcm_pkg::result_t result_o
);

  logic             valid_q, valid_d;
  bcm_pkg::result_t result_q;

  assign load_ok_o = !valid_q || ready_i;
  assign valid_d   = load_ok_o ? load_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ok_o && load_valid_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

FILE: hw/rtl/battery_charge_monitor_controller.sv
// ----------------------------------------------------------------------------
// battery_charge_monitor_controller
// An item that is taken passes the input register, then the single update pass
// into the result register. One item per cycle while the result is not stalled.
// A stalled result holds the input register. Asynchronous reset clears pack
// data and pin state, but not the result register.
// ----------------------------------------------------------------------------
module battery_charge_monitor_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic [10:0] can_id_i,
  input  logic [47:0] can_payload_i,
  input  logic        door_closed_i,
  input  logic        ramp_due_i,
  input  logic [4:0]  reg_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        charge_enable_o,
  output logic        led_charging_o,
  output logic        led_full_o,
  output logic [11:0] dac_code_o,
  output logic        send_wake_o,
  output logic [15:0] read_data_o,
  output logic        read_error_o,
  output logic [6:0]  charge_percent_o
);

  bcm_pkg::item_t   item_in;
  bcm_pkg::item_t   item_held;
  bcm_pkg::result_t result_nx;
  bcm_pkg::result_t result_out;
  logic             held_valid;
  logic             load_ok;
  logic             fire;

  always_comb begin
    item_in.action      = action_i;
    item_in.can_id      = can_id_i;
    item_in.can_payload = can_payload_i;
    item_in.door_closed = door_closed_i;
    item_in.ramp_due    = ramp_due_i;
    item_in.reg_index   = reg_index_i;
  end

  assign fire = held_valid && load_ok;

  bcm_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .item_i    (item_in),
    .advance_i (load_ok),
    .valid_o   (held_valid),
    .item_o    (item_held)
  );

  bcm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (item_held),
    .result_o    (result_nx)
  );

  bcm_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (held_valid),
    .result_i     (result_nx),
    .load_ok_o    (load_ok),
    .valid_o      (out_valid_o),
    .ready_i      (out_ready_i),
    .result_o     (result_out)
  );

  assign charge_enable_o  = result_out.charge_enable;
  assign led_charging_o   = result_out.led_charging;
  assign led_full_o       = result_out.led_full;
  assign dac_code_o       = result_out.dac_code;
  assign send_wake_o      = result_out.send_wake;
  assign read_data_o      = result_out.read_data;
  assign read_error_o     = result_out.read_error;
  assign charge_percent_o = result_out.charge_percent;

endmodule

FILE: hw/rtl/bcm_checker.sv
// ----------------------------------------------------------------------------
// bcm_checker
// Port-level checks of the battery charge monitor, bound to the top level.
// ----------------------------------------------------------------------------
`include "battery_charge_monitor_controller_assert.svh"

module bcm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        led_charging_o,
  input logic        led_full_o,
  input logic        send_wake_o,
  input logic [15:0] read_data_o,
  input logic        read_error_o,
  input logic [6:0]  charge_percent_o
);

  `BCM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `BCM_ASSERT_NOW(a_err_no_data, out_valid_o && read_error_o, read_data_o == 16'd0)
  `BCM_ASSERT_NOW(a_wake_no_read, out_valid_o && send_wake_o, !read_error_o && read_data_o == 16'd0)
  `BCM_ASSERT_NOW(a_leds_apart, out_valid_o, !(led_charging_o && led_full_o))
  `BCM_ASSERT_NOW(a_pct_range, out_valid_o, charge_percent_o <= 7'd100)

endmodule

bind battery_charge_monitor_controller bcm_checker u_bcm_checker (.*);
